// ===== hw/rtl/rme_pkg.sv =====
// Shared constants, types and functions for the rotation-matrix to Euler block.
`default_nettype none
package rme_pkg;
	localparam int unsigned NSTEP = 16;
	localparam int unsigned PIPE_DEPTH = 34; // stages before the output register
	localparam logic signed [16:0] ONE_Q14 = 17'sd16384;
	localparam logic signed [15:0] PI_Q13 = 16'sd25736;
	localparam logic signed [14:0] HPI_Q13 = 15'sd12868;
	localparam logic signed [19:0] HPI_Q16 = 20'sd102944;

	typedef enum logic [1:0] {
		LOCK_NONE = 2'd0,
		LOCK_NEG  = 2'd1,
		LOCK_POS  = 2'd2
	} lock_t;

	// one CORDIC lane: vector, angle accumulator, zero-vector flag
	typedef struct packed {
		logic signed [25:0] vx;
		logic signed [25:0] vy;
		logic signed [19:0] z;
		logic               zero;
	} cordic_t;

	function automatic logic signed [19:0] atan_tab(input logic [3:0] i);
		case (i)
			4'd0:    atan_tab = 20'sd51472;
			4'd1:    atan_tab = 20'sd30386;
			4'd2:    atan_tab = 20'sd16055;
			4'd3:    atan_tab = 20'sd8150;
			4'd4:    atan_tab = 20'sd4091;
			4'd5:    atan_tab = 20'sd2047;
			4'd6:    atan_tab = 20'sd1024;
			4'd7:    atan_tab = 20'sd512;
			4'd8:    atan_tab = 20'sd256;
			4'd9:    atan_tab = 20'sd128;
			4'd10:   atan_tab = 20'sd64;
			4'd11:   atan_tab = 20'sd32;
			4'd12:   atan_tab = 20'sd16;
			4'd13:   atan_tab = 20'sd8;
			4'd14:   atan_tab = 20'sd4;
			default: atan_tab = 20'sd2;
		endcase
	endfunction

	function automatic logic signed [16:0] clamp_q14(input logic signed [15:0] v);
		if (v > 16'sd16384)       clamp_q14 = ONE_Q14;
		else if (v < -16'sd16384) clamp_q14 = -ONE_Q14;
		else                      clamp_q14 = 17'(v);
	endfunction

	// pre-rotation into the right half plane; inputs are clamped Q1.14
	function automatic cordic_t cordic_init(input logic signed [17:0] y,
		input logic signed [17:0] x);
		cordic_t r;
		logic signed [25:0] sx, sy;
		sx = {x, 8'd0};
		sy = {y, 8'd0};
		r.zero = (x == 18'sd0) && (y == 18'sd0);
		r.z = '0;
		r.vx = sx;
		r.vy = sy;
		if (sx < 0) begin
			if (sy >= 0) begin
				r.vx = sy; r.vy = -sx; r.z = HPI_Q16;
			end else begin
				r.vx = -sy; r.vy = sx; r.z = -HPI_Q16;
			end
		end
		return r;
	endfunction

	function automatic cordic_t cordic_step(input cordic_t a, input logic [3:0] i);
		cordic_t r;
		logic signed [25:0] dx, dy;
		dx = a.vy >>> i;
		dy = a.vx >>> i;
		r = a;
		if (a.vy >= 0) begin
			r.vx = a.vx + dx; r.vy = a.vy - dy; r.z = a.z + atan_tab(i);
		end else begin
			r.vx = a.vx - dx; r.vy = a.vy + dy; r.z = a.z - atan_tab(i);
		end
		return r;
	endfunction

	// floor((z+4)/8), saturated to +-lim; zero vector gives 0
	function automatic logic signed [15:0] cordic_out(input cordic_t a,
		input logic signed [15:0] lim);
		logic signed [19:0] q;
		q = (a.z + 20'sd4) >>> 3;
		if (a.zero)                   cordic_out = '0;
		else if (q > 20'(lim))        cordic_out = lim;
		else if (q < -20'(lim))       cordic_out = -lim;
		else                          cordic_out = q[15:0];
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/rotation_matrix_to_euler.sv =====
// Top level: rotation matrix to X-Y-Z Euler angles, pipelined CORDIC.
//
//  channel | direction | handshake     | payload
//  in      | into      | valid / stall | m00 m01 m02 m10 m11 m12 m22
//  out     | out of    | valid / stall | angle_x angle_y angle_z lock_case
//
// One beat per cycle while the output does not stall. Stages: clamp (1), radicand (1),
// square root (15), Y lane init (1), 16 CORDIC stages run side by side on
// three lanes, then the output register (1).
// The Y lane starts after the root; X and Z lanes ride delay lines meanwhile.
// A stall freezes the whole pipe; stall on in is the output stall while the
// output register holds a beat. Reset clears valid bits only.
`default_nettype none
module rotation_matrix_to_euler
	import rme_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] m00,
	input  wire logic signed [15:0] m01,
	input  wire logic signed [15:0] m02,
	input  wire logic signed [15:0] m10,
	input  wire logic signed [15:0] m11,
	input  wire logic signed [15:0] m12,
	input  wire logic signed [15:0] m22,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      angle_x,
	output logic signed [14:0]      angle_y,
	output logic signed [15:0]      angle_z,
	output logic [1:0]              lock_case
);
	logic en;
	// pipe advances when output register is free or being emptied
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	logic [PIPE_DEPTH-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid};
	end

	// stage 1: clamp, lock decision, x/z lane sources
	logic signed [16:0] a02_s1;
	lock_t              lk_s1;
	cordic_t            cx_s1, cz_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			a02_s1 <= clamp_q14(m02);
			if (clamp_q14(m02) <= -ONE_Q14) begin
				lk_s1 <= LOCK_NEG;
				cx_s1 <= cordic_init(18'(clamp_q14(m10)), 18'(clamp_q14(m11)));
			end else if (clamp_q14(m02) >= ONE_Q14) begin
				lk_s1 <= LOCK_POS;
				cx_s1 <= cordic_init(18'(clamp_q14(m10)), 18'(clamp_q14(m11)));
			end else begin
				lk_s1 <= LOCK_NONE;
				cx_s1 <= cordic_init(-18'(clamp_q14(m12)), 18'(clamp_q14(m22)));
			end
			cz_s1 <= cordic_init(-18'(clamp_q14(m01)), 18'(clamp_q14(m00)));
		end
	end

	// stage 2: 2^28 - s*s (s*s <= 2^28)
	logic signed [16:0] a02_s2;
	logic [28:0]        rad_s2;
	lock_t              lk_s2;
	cordic_t            cx_s2, cz_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			a02_s2 <= a02_s1;
			rad_s2 <= 29'(34'sd268435456 - 34'(a02_s1 * a02_s1));
			lk_s2  <= lk_s1;
			cx_s2  <= cx_s1;
			cz_s2  <= cz_s1;
		end
	end

	// square root, 15 stages; sideband delayed to match
	logic [14:0] root;
	rme_isqrt_pipe u_sqrt (.clk(clk), .en(en), .n_in(rad_s2), .root_out(root));

	logic signed [16:0] a02_d [0:15];
	lock_t              lk_d  [0:15];
	cordic_t            cx_d  [0:15];
	cordic_t            cz_d  [0:15];
	assign a02_d[0] = a02_s2;
	assign lk_d[0]  = lk_s2;
	assign cx_d[0]  = cx_s2;
	assign cz_d[0]  = cz_s2;
	for (genvar k = 0; k < 15; k++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en) begin
				a02_d[k + 1] <= a02_d[k];
				lk_d[k + 1]  <= lk_d[k];
				cx_d[k + 1]  <= cx_d[k];
				cz_d[k + 1]  <= cz_d[k];
			end
		end
	end

	// stage 18: Y lane init, then 16 CORDIC stages on all three lanes
	cordic_t cy [0:16];
	cordic_t cx [0:16];
	cordic_t cz [0:16];
	lock_t   lk [0:16];
	always_ff @(posedge clk) begin
		if (en) begin
			cy[0] <= cordic_init(18'(a02_d[15]), {3'd0, root});
			cx[0] <= cx_d[15];
			cz[0] <= cz_d[15];
			lk[0] <= lk_d[15];
		end
	end
	for (genvar i = 0; i < NSTEP; i++) begin : g_cor
		always_ff @(posedge clk) begin
			if (en) begin
				cy[i + 1] <= cordic_step(cy[i], 4'(i));
				cx[i + 1] <= cordic_step(cx[i], 4'(i));
				cz[i + 1] <= cordic_step(cz[i], 4'(i));
				lk[i + 1] <= lk[i];
			end
		end
	end

	// output register: final scaling, lock overrides
	logic signed [15:0] ax_n, ay_n, az_n;
	always_comb begin
		ax_n = cordic_out(cx[NSTEP], PI_Q13);
		ay_n = cordic_out(cy[NSTEP], 16'(HPI_Q13));
		az_n = cordic_out(cz[NSTEP], PI_Q13);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= vld_q[PIPE_DEPTH-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lock_case <= lk[NSTEP];
			case (lk[NSTEP])
				LOCK_NEG: begin
					angle_x <= -ax_n;
					angle_y <= -HPI_Q13;
					angle_z <= '0;
				end
				LOCK_POS: begin
					angle_x <= ax_n;
					angle_y <= HPI_Q13;
					angle_z <= '0;
				end
				default: begin
					angle_x <= ax_n;
					angle_y <= ay_n[14:0];
					angle_z <= az_n;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/rme_isqrt_pipe.sv =====
// Pipelined integer square root, one result bit per stage, stall-aware.
`default_nettype none
module rme_isqrt_pipe
	import rme_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [28:0] n_in,
	output logic      [14:0] root_out
);
	// 15 stages of restoring root, bit pairs from 2^28 downward
	logic [28:0] rem_s [0:15];
	logic [28:0] rt_s  [0:15];

	assign rem_s[0] = n_in;
	assign rt_s[0]  = '0;

	for (genvar k = 0; k < 15; k++) begin : g_st
		logic [28:0] bitv, rem_n, rt_n;
		always_comb begin
			bitv = 29'd1 << (28 - 2 * k);
			if (rem_s[k] >= rt_s[k] + bitv) begin
				rem_n = rem_s[k] - (rt_s[k] + bitv);
				rt_n  = (rt_s[k] >> 1) + bitv;
			end else begin
				rem_n = rem_s[k];
				rt_n  = rt_s[k] >> 1;
			end
		end
		logic [28:0] rem_q, rt_q;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q <= rem_n;
				rt_q  <= rt_n;
			end
		end
		assign rem_s[k + 1] = rem_q;
		assign rt_s[k + 1]  = rt_q;
	end

	assign root_out = rt_s[15][14:0];
endmodule
`default_nettype wire

// ===== hw/rtl/rme_checker.sv =====
// Port-level checker for the Euler block, bound to the top level.
`default_nettype none
module rme_props
	import rme_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic signed [15:0] angle_x,
	input wire logic signed [14:0] angle_y,
	input wire logic signed [15:0] angle_z,
	input wire logic [1:0]         lock_case
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(angle_x) && $stable(angle_y))
		else $error("stalled beat changed");
	a_lockz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && lock_case != LOCK_NONE |-> angle_z == 16'sd0)
		else $error("locked beat has nonzero z");
	a_locky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && lock_case == LOCK_POS |-> angle_y == HPI_Q13)
		else $error("positive lock y wrong");
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> lock_case != 2'd3)
		else $error("bad lock code");
	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while output blocked");
endmodule

bind rotation_matrix_to_euler rme_props u_rme_props (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall), .out_valid(out_valid),
	.out_stall(out_stall), .angle_x(angle_x), .angle_y(angle_y),
	.angle_z(angle_z), .lock_case(lock_case)
);
`default_nettype wire

// ===== tb/sv/rme_checker.sv =====
// Checker: watches both channels, predicts Euler angles and compares each output beat.
module rme_checker
	import rme_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [15:0] m00,
	input  logic signed [15:0] m01,
	input  logic signed [15:0] m02,
	input  logic signed [15:0] m10,
	input  logic signed [15:0] m11,
	input  logic signed [15:0] m12,
	input  logic signed [15:0] m22,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [15:0] angle_x,
	input  logic signed [14:0] angle_y,
	input  logic signed [15:0] angle_z,
	input  logic [1:0]         lock_case,
	output int                 errors,
	output int                 pending,
	output int                 n_checked,
	output int                 n_lock
);
	typedef struct {
		int    ax;
		int    ay;
		int    az;
		lock_t lk;
	} angles_t;

	angles_t euler_q[$];

	function automatic int clampq(input logic signed [15:0] v);
		int t;
		t = v;
		if (t > 16384) return 16384;
		if (t < -16384) return -16384;
		return t;
	endfunction

	function automatic int limit(input int v, input int lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// >>> on int is arithmetic, matching floor division
	function automatic int vec_angle(input int y, input int x);
		int vx, vy, z, t, dx, dy;
		int tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2};
		if (x == 0 && y == 0) return 0;
		vx = x * 256;
		vy = y * 256;
		z = 0;
		if (vx < 0) begin
			t = vx;
			if (vy >= 0) begin
				vx = vy; vy = -t; z = 102944;
			end else begin
				vx = -vy; vy = t; z = -102944;
			end
		end
		for (int i = 0; i < 16; i++) begin
			dx = vy >>> i;
			dy = vx >>> i;
			if (vy >= 0) begin
				vx += dx; vy -= dy; z += tab[i];
			end else begin
				vx -= dx; vy += dy; z -= tab[i];
			end
		end
		return limit((z + 4) >>> 3, 25736);
	endfunction

	function automatic int root_floor(input longint n);
		longint r;
		r = 0;
		while ((r + 1) * (r + 1) <= n) r++;
		return int'(r);
	endfunction

	function automatic angles_t to_euler(input int a00, a01, a02, a10, a11, a12, a22);
		angles_t e;
		if (a02 <= -16384) begin
			e.lk = LOCK_NEG; e.ay = -12868; e.ax = -vec_angle(a10, a11); e.az = 0;
		end else if (a02 >= 16384) begin
			e.lk = LOCK_POS; e.ay = 12868; e.ax = vec_angle(a10, a11); e.az = 0;
		end else begin
			e.lk = LOCK_NONE;
			e.ay = limit(vec_angle(a02, root_floor(268435456 - a02 * a02)), 12868);
			e.ax = vec_angle(-a12, a22);
			e.az = vec_angle(-a01, a00);
		end
		e.ax = limit(e.ax, 25736);
		e.az = limit(e.az, 25736);
		return e;
	endfunction

	assign pending = euler_q.size();

	always @(posedge clk or negedge arst_n) begin
		angles_t e;
		if (!arst_n) begin
			errors <= 0;
			n_checked <= 0;
			n_lock <= 0;
		end else begin
			if (in_valid && !in_stall)
				euler_q.push_back(to_euler(clampq(m00), clampq(m01), clampq(m02),
					clampq(m10), clampq(m11), clampq(m12), clampq(m22)));
			if (out_valid && !out_stall) begin
				if (euler_q.size() == 0) begin
					$display("%0t: unexpected beat x=%0d y=%0d z=%0d lock=%0d", $time,
						angle_x, angle_y, angle_z, lock_case);
					errors <= errors + 1;
				end else begin
					e = euler_q.pop_front();
					n_checked <= n_checked + 1;
					if (e.lk != LOCK_NONE) n_lock <= n_lock + 1;
					if (int'(angle_x) != e.ax || int'(angle_y) != e.ay ||
						int'(angle_z) != e.az || lock_case != e.lk) begin
						$display("%0t: mismatch exp x=%0d y=%0d z=%0d lock=%0d, got x=%0d y=%0d z=%0d lock=%0d",
							$time, e.ax, e.ay, e.az, e.lk,
							angle_x, angle_y, angle_z, lock_case);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

// ===== tb/sv/testbench.sv =====
// Top of the testbench: stimulus, flow control and verdict for the Euler block.
module testbench;
	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic out_stall = 0;
	logic signed [15:0] m00 = 0, m01 = 0, m02 = 0, m10 = 0, m11 = 0, m12 = 0, m22 = 0;
	logic in_stall, out_valid;
	logic signed [15:0] angle_x, angle_z;
	logic signed [14:0] angle_y;
	logic [1:0] lock_case;
	int errors, pending, n_checked, n_lock;
	int cycles = 0;
	int stall_mode = 0;

	localparam int CYCLE_LIMIT = 200000;

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	rotation_matrix_to_euler dut (.*);

	rme_checker chk (.*);

	// watchdog: counts every rising edge
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats outstanding", cycles, pending);
			$display("testbench: FAIL");
			$finish;
		end
	end

	// receiver back-pressure: mode changes now and then, covering no stall,
	// light, heavy and long blocked stretches
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= ($urandom_range(0, 15) != 0);
		endcase
	end

	// a value anywhere in 16 bits, biased toward the legal range and its edges
	function automatic logic signed [15:0] entry_val();
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: return 16'sd16384;
			2: return -16'sd16384;
			3: return 16'sd0;
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	// present one beat and hold it until the block takes it
	task automatic send(input logic signed [15:0] a00, a01, a02, a10, a11, a12, a22);
		m00 <= a00; m01 <= a01; m02 <= a02; m10 <= a10;
		m11 <= a11; m12 <= a12; m22 <= a22;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// a zero-length gap leaves valid high for the next beat
	task automatic idle(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	initial begin
		int burst;
		int wait_cnt;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: identity, lock cases, zero vectors, negative axis, clamping
		send(16384, 0, 0, 0, 16384, 0, 16384);
		send(0, 0, -16384, 0, 16384, 0, 0);
		send(0, 0, 16384, 0, 16384, 0, 0);
		send(0, 0, -32768, 16384, 0, 0, 0);
		send(0, 0, 32767, -16384, -16384, 0, 0);
		send(0, 0, 0, 0, 0, 0, 0);
		send(0, 0, 16384, 0, 0, 0, 0);
		send(-16384, 0, 0, 0, 0, 0, -16384);
		send(-16384, 16384, 0, 0, 0, -16384, -16384);
		send(-32768, -32768, 16383, 32767, 32767, -32768, 32767);
		send(16384, 16384, -16383, 0, 0, 16384, 16384);
		send(-1, 1, 1, -1, 1, 1, -1);
		send(-1, -1, -1, -1, -1, -1, -1);
		send(16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'h7FFF, 16'h8000, 16'h1234);
		send(11585, 11585, 11585, 11585, -11585, -11585, 11585);
		send(16383, -16383, -16383, 16383, -16383, 16383, -16383);
		idle(3);

		// random: bursts with gaps, a few long stretches without gaps
		for (int n = 0; n < 1550; ) begin
			burst = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 120 : 12);
			for (int k = 0; k < burst; k++) begin
				send(entry_val(), entry_val(), entry_val(), entry_val(),
					entry_val(), entry_val(), entry_val());
				n++;
			end
			idle($urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 8));
		end
		in_valid <= 1'b0;

		wait_cnt = 0;
		while (pending != 0 && wait_cnt < 20000) begin
			@(negedge clk);
			wait_cnt++;
		end
		repeat (60) @(negedge clk);

		$display("checked %0d result beats, %0d of them in gimbal lock", n_checked, n_lock);
		$display("stimulus ran under varied input gaps and output back-pressure");
		if (errors == 0 && pending == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end
endmodule
